// ----- rtl/tlbsc_pkg.sv -----
package tlbsc_pkg;

  localparam int unsigned PAGE_W = 52;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned SLOT_W = 4;

  // write beat into the page/frame store
  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
  } tlbsc_wr_t;

endpackage

// ----- rtl/tlbsc_entry_ram.sv -----
module tlbsc_entry_ram
  import tlbsc_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 4
) (
  input  logic                  clk_i,
  input  tlbsc_wr_t             wr_i,
  input  logic [INDEX_BITS-1:0] wr_addr_i,
  input  logic [INDEX_BITS-1:0] rd_addr_i,
  output logic [PAGE_W-1:0]     page_o,
  output logic [PAGE_W-1:0]     frame_o
);

  localparam int unsigned Depth = 1 << INDEX_BITS;

  logic [PAGE_W-1:0] page_mem  [Depth];
  logic [PAGE_W-1:0] frame_mem [Depth];
  logic [PAGE_W-1:0] page_q;
  logic [PAGE_W-1:0] frame_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      page_mem[wr_addr_i]  <= wr_i.page;
      frame_mem[wr_addr_i] <= wr_i.frame;
    end
  end

  // registered read, one address per cycle
  always_ff @(posedge clk_i) begin
    page_q  <= page_mem[rd_addr_i];
    frame_q <= frame_mem[rd_addr_i];
  end

  assign page_o  = page_q;
  assign frame_o = frame_q;

endmodule

// ----- rtl/tlb_lookup_second_chance_unit.sv -----
// Fully associative TLB with second-chance replacement, 2^INDEX_BITS slots.
// Pulse start while busy is low to hand in one access; busy stays high while
// it is worked on, and the result comes back as a single-cycle beat marked by
// done_o. The receiver cannot stall: sample the result ports in the cycle
// done_o is high. Page and frame numbers sit in a single-port-read store, so
// one slot is compared per cycle by the one page comparator. A hit in slot k
// returns once the scan reaches slot k. A miss scans all N slots and, if some
// slot is invalid, fills the lowest one in the fill state before its beat
// comes back. With the TLB full, the second-chance sweep from slot 0 first
// visits up to N+1 slots, clearing used bits, until an unused one turns up,
// then fills it. A new access can start in the cycle done_o is high. No
// clearing pass: valid, used and dirty bits are flops cleared by reset.
module tlb_lookup_second_chance_unit
  import tlbsc_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = 4,
  parameter int unsigned OFFSET_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [PAGE_W-1:0] virt_page_i,
  input  logic [OFS_W-1:0]  page_offset_i,
  input  logic              is_write_i,
  input  logic [PAGE_W-1:0] walk_frame_i,
  input  logic              walk_dirty_i,
  output logic              done_o,
  output logic [ADDR_W-1:0] phys_addr_o,
  output logic              hit_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              evicted_o,
  output logic [PAGE_W-1:0] evicted_page_o,
  output logic              evicted_dirty_o
);

  localparam int unsigned Slots = 1 << INDEX_BITS;
  localparam logic [ADDR_W-1:0] OfsMask = (ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_FILL  = 2'd3;

  logic [1:0]            state_q;
  logic [INDEX_BITS-1:0] idx_q;       // scan / sweep position
  logic [INDEX_BITS-1:0] victim_q;
  logic                  inv_found_q; // an invalid slot was seen during scan (victim_q holds the lowest)
  logic                  evict_q;
  logic [Slots-1:0]      valid_q;
  logic [Slots-1:0]      used_q;
  logic [Slots-1:0]      dirty_q;

  // latched access
  logic [PAGE_W-1:0]     vpage_q;
  logic [OFS_W-1:0]      ofs_q;
  logic                  wr_q;
  logic [PAGE_W-1:0]     wframe_q;
  logic                  wdirty_q;

  // result registers
  logic                  done_q;
  logic [ADDR_W-1:0]     phys_q;
  logic                  hit_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  evicted_q;
  logic [PAGE_W-1:0]     ev_page_q;
  logic                  ev_dirty_q;

  logic [INDEX_BITS-1:0] rd_addr;
  logic [PAGE_W-1:0]     rd_page;
  logic [PAGE_W-1:0]     rd_frame;
  tlbsc_wr_t             wr_beat;
  logic                  accept;
  logic                  match;
  logic                  last;
  logic [ADDR_W-1:0]     ofs_part;

  assign accept   = start && (state_q == S_IDLE);
  assign match    = valid_q[idx_q] && (rd_page == vpage_q);
  assign last     = &idx_q;
  assign ofs_part = {{(ADDR_W-OFS_W){1'b0}}, ofs_q} & OfsMask;

  // store read address: slot 0 at accept, next slot while scanning,
  // the victim when the sweep settles on it
  always_comb begin
    unique case (state_q)
      S_SCAN:  rd_addr = idx_q + INDEX_BITS'(1);
      S_SWEEP: rd_addr = idx_q;
      default: rd_addr = '0;
    endcase
  end

  assign wr_beat.en    = (state_q == S_FILL);
  assign wr_beat.page  = vpage_q;
  assign wr_beat.frame = wframe_q;

  tlbsc_entry_ram #(
    .INDEX_BITS (INDEX_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr_beat),
    .wr_addr_i (victim_q),
    .rd_addr_i (rd_addr),
    .page_o    (rd_page),
    .frame_o   (rd_frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      victim_q    <= '0;
      inv_found_q <= 1'b0;
      evict_q     <= 1'b0;
      valid_q     <= '0;
      used_q      <= '0;
      dirty_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q       <= '0;
            inv_found_q <= 1'b0;
            evict_q     <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            used_q[idx_q]  <= 1'b1;
            dirty_q[idx_q] <= dirty_q[idx_q] | wr_q;
            done_q         <= 1'b1;
            state_q        <= S_IDLE;
          end else begin
            if (!valid_q[idx_q] && !inv_found_q) begin
              inv_found_q <= 1'b1;
              victim_q    <= idx_q;
            end
            if (last) begin
              idx_q <= '0;
              if (inv_found_q || !valid_q[idx_q]) begin
                state_q <= S_FILL;
              end else begin
                state_q <= S_SWEEP;
              end
            end else begin
              idx_q <= idx_q + INDEX_BITS'(1);
            end
          end
        end
        S_SWEEP: begin
          // clock hand: clear used bits until an unused slot turns up
          if (!used_q[idx_q]) begin
            victim_q <= idx_q;
            evict_q  <= 1'b1;
            state_q  <= S_FILL;
          end else begin
            used_q[idx_q] <= 1'b0;
            idx_q         <= idx_q + INDEX_BITS'(1);
          end
        end
        S_FILL: begin
          valid_q[victim_q] <= 1'b1;
          used_q[victim_q]  <= 1'b1;
          dirty_q[victim_q] <= wdirty_q;
          done_q            <= 1'b1;
          state_q           <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload: access latch and result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vpage_q  <= virt_page_i;
      ofs_q    <= page_offset_i;
      wr_q     <= is_write_i;
      wframe_q <= walk_frame_i;
      wdirty_q <= walk_dirty_i;
    end
    if (state_q == S_SCAN && match) begin
      phys_q     <= ({{(ADDR_W-PAGE_W){1'b0}}, rd_frame} << OFFSET_BITS) | ofs_part;
      hit_q      <= 1'b1;
      slot_q     <= SLOT_W'(idx_q);
      evicted_q  <= 1'b0;
      ev_page_q  <= '0;
      ev_dirty_q <= 1'b0;
    end else if (state_q == S_FILL) begin
      // rd_page holds the victim's old page after an eviction
      phys_q     <= ({{(ADDR_W-PAGE_W){1'b0}}, wframe_q} << OFFSET_BITS) | ofs_part;
      hit_q      <= 1'b0;
      slot_q     <= SLOT_W'(victim_q);
      evicted_q  <= evict_q;
      ev_page_q  <= evict_q ? rd_page : '0;
      ev_dirty_q <= evict_q && dirty_q[victim_q];
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign phys_addr_o     = phys_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_o       = evicted_q;
  assign evicted_page_o  = ev_page_q;
  assign evicted_dirty_o = ev_dirty_q;

endmodule

// ----- dv/tb_tlb_lookup_second_chance_unit.sv -----
module tb_tlb_lookup_second_chance_unit;
  import tlbsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INDEX_BITS  = 4;
  localparam int unsigned OFFSET_BITS = 12;
  localparam int unsigned NSLOT       = 1 << INDEX_BITS;
  localparam logic [ADDR_W-1:0] OFS_MASK = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [PAGE_W-1:0] PMAX     = {PAGE_W{1'b1}};
  // worst access: full scan, full sweep, fill; used for the drain tail
  localparam int unsigned TAIL_CYC   = 2 * NSLOT + 16;
  localparam int unsigned RAND_SEGS  = 15;
  localparam int unsigned SEG_ITEMS  = 60;
  localparam int unsigned POOL_MAX   = 32;

  // one access beat as handed to the block
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs;
    logic              wr;
    logic [PAGE_W-1:0] frame;
    logic              wdirty;
  } access_t;

  // one translation result beat
  typedef struct packed {
    logic [ADDR_W-1:0] pa;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              ev;
    logic [PAGE_W-1:0] ev_page;
    logic              ev_dirty;
  } xlate_t;

  // directed stimulus row: lit set means the expected beat is typed in
  typedef struct packed {
    access_t a;
    logic    lit;
    xlate_t  x;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [PAGE_W-1:0] virt_page;
  logic [OFS_W-1:0]  page_offset;
  logic              is_write;
  logic [PAGE_W-1:0] walk_frame;
  logic              walk_dirty;
  logic              done_o;
  logic [ADDR_W-1:0] phys_addr_o;
  logic              hit_o;
  logic [SLOT_W-1:0] slot_o;
  logic              evicted_o;
  logic [PAGE_W-1:0] evicted_page_o;
  logic              evicted_dirty_o;

  // shadow TLB state kept by the predictor
  logic              tlb_valid [NSLOT];
  logic              tlb_used  [NSLOT];
  logic              tlb_dirty [NSLOT];
  logic [PAGE_W-1:0] tlb_page  [NSLOT];
  logic [PAGE_W-1:0] tlb_frame [NSLOT];

  xlate_t   xlate_q[$];   // translations still owed by the block, oldest first
  dir_row_t dir_rows[$];
  logic [PAGE_W-1:0] page_pool[POOL_MAX];
  int unsigned err_cnt = 0;

  tlb_lookup_second_chance_unit #(
    .INDEX_BITS (INDEX_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .virt_page_i    (virt_page),
    .page_offset_i  (page_offset),
    .is_write_i     (is_write),
    .walk_frame_i   (walk_frame),
    .walk_dirty_i   (walk_dirty),
    .done_o         (done_o),
    .phys_addr_o    (phys_addr_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .evicted_dirty_o(evicted_dirty_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Translate one access against the shadow TLB and update it.
  // Order: associative hit check, lowest invalid slot, then clock sweep.
  function automatic xlate_t tlb_translate(input access_t a);
    xlate_t      r;
    int unsigned victim;
    int unsigned s;
    bit          found;
    r = '0;
    found = 1'b0;
    victim = 0;
    for (int unsigned i = 0; i < NSLOT; i++) begin
      if (!found && tlb_valid[i] && tlb_page[i] == a.page) begin
        tlb_used[i]  = 1'b1;
        tlb_dirty[i] = tlb_dirty[i] | a.wr;
        r.pa   = (ADDR_W'(tlb_frame[i]) << OFFSET_BITS) | (ADDR_W'(a.ofs) & OFS_MASK);
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i);
        found  = 1'b1;
      end
    end
    if (found) return r;

    for (int unsigned i = 0; i < NSLOT; i++) begin
      if (!found && !tlb_valid[i]) begin
        victim = i;
        found  = 1'b1;
      end
    end

    if (!found) begin
      // second chance: used slots get cleared and skipped, wraps past the end
      for (int unsigned i = 0; i < NSLOT + 2; i++) begin
        s = i % NSLOT;
        if (!found) begin
          if (!tlb_used[s]) begin
            victim = s;
            found  = 1'b1;
          end else begin
            tlb_used[s] = 1'b0;
          end
        end
      end
      r.ev       = 1'b1;
      r.ev_page  = tlb_page[victim];
      r.ev_dirty = tlb_dirty[victim];
    end

    tlb_page[victim]  = a.page;
    tlb_frame[victim] = a.frame;
    tlb_valid[victim] = 1'b1;
    tlb_used[victim]  = 1'b1;
    tlb_dirty[victim] = a.wdirty;

    r.pa   = (ADDR_W'(a.frame) << OFFSET_BITS) | (ADDR_W'(a.ofs) & OFS_MASK);
    r.hit  = 1'b0;
    r.slot = SLOT_W'(victim);
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] rand_page();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PAGE_W-1:0];
  endfunction

  // mostly back-to-back or short gaps, now and then a long one; none when quiet
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(input access_t a, input bit lit, input xlate_t x);
    dir_row_t row;
    row.a   = a;
    row.lit = lit;
    row.x   = x;
    dir_rows.push_back(row);
  endfunction

  // Present one access beat and hold it until accepted (start high, busy low
  // at the edge). The expected beat is queued at the accepting edge.
  task automatic issue(input access_t a, input bit lit, input xlate_t lit_x,
                       input int unsigned gap);
    xlate_t model_x;
    start       <= 1'b1;
    virt_page   <= a.page;
    page_offset <= a.ofs;
    is_write    <= a.wr;
    walk_frame  <= a.frame;
    walk_dirty  <= a.wdirty;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    model_x = tlb_translate(a);
    xlate_q.push_back(lit ? lit_x : model_x);
    // start is only dropped when a gap follows, so it never toggles in one step
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result checker: the receiver cannot stall, so every done_o cycle is a beat.
  // Outputs are read at the edge that closes the strobe cycle.
  always @(posedge clk_i) begin
    xlate_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (xlate_q.size() == 0) begin
        $error("result beat with no access outstanding");
        err_cnt++;
      end else begin
        want = xlate_q.pop_front();
        if (phys_addr_o !== want.pa) begin
          $error("phys_addr: expected %h, got %h", want.pa, phys_addr_o);
          err_cnt++;
        end
        if (hit_o !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, hit_o);
          err_cnt++;
        end
        if (slot_o !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot_o);
          err_cnt++;
        end
        if (evicted_o !== want.ev) begin
          $error("evicted: expected %b, got %b", want.ev, evicted_o);
          err_cnt++;
        end
        if (evicted_page_o !== want.ev_page) begin
          $error("evicted_page: expected %h, got %h", want.ev_page, evicted_page_o);
          err_cnt++;
        end
        if (evicted_dirty_o !== want.ev_dirty) begin
          $error("evicted_dirty: expected %b, got %b", want.ev_dirty, evicted_dirty_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    access_t     a;
    int unsigned pool_n;
    int unsigned r;
    bit          quiet;

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    virt_page   <= '0;
    page_offset <= '0;
    is_write    <= 1'b0;
    walk_frame  <= '0;
    walk_dirty  <= 1'b0;
    for (int unsigned i = 0; i < NSLOT; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_used[i]  = 1'b0;
      tlb_dirty[i] = 1'b0;
      tlb_page[i]  = '0;
      tlb_frame[i] = '0;
    end

    // Directed rows. Fields: page, offset, write, walk frame, walk dirty;
    // expected: phys, hit, slot, evicted, evicted page, evicted dirty.
    // empty TLB, zero everything: fill of slot 0
    add_row({52'h0, 12'h000, 1'b0, 52'h0, 1'b0}, 1'b1,
            {64'h0, 1'b0, 4'd0, 1'b0, 52'h0, 1'b0});
    // all-ones fields: fill of slot 1, address saturates to all ones
    add_row({PMAX, 12'hFFF, 1'b1, PMAX, 1'b1}, 1'b1,
            {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd1, 1'b0, 52'h0, 1'b0});
    // write hit on slot 0: walker frame ignored, entry goes dirty
    add_row({52'h0, 12'hABC, 1'b1, 52'h1234, 1'b0}, 1'b1,
            {64'h0000_0000_0000_0ABC, 1'b1, 4'd0, 1'b0, 52'h0, 1'b0});
    // read hit on slot 1
    add_row({PMAX, 12'h000, 1'b0, 52'h0, 1'b0}, 1'b1,
            {64'hFFFF_FFFF_FFFF_F000, 1'b1, 4'd1, 1'b0, 52'h0, 1'b0});
    // fill the remaining slots, every entry ends up used
    for (int unsigned k = 2; k < NSLOT; k++) begin
      a.page   = 52'h100 + PAGE_W'(k);
      a.ofs    = OFS_W'($urandom());
      a.wr     = 1'($urandom());
      a.frame  = rand_page();
      a.wdirty = 1'($urandom());
      add_row(a, 1'b0, '0);
    end
    // full TLB, all used: sweep clears every used bit and wraps to slot 0
    add_row({52'hA_5A5A_5A5A_5A5A, 12'h555, 1'b0, 52'h5_A5A5_A5A5_A5A5, 1'b0}, 1'b1,
            {64'h5A5A_5A5A_5A5A_5555, 1'b0, 4'd0, 1'b1, 52'h0, 1'b1});
    // slot 0 used again, gets its second chance; slot 1 is the victim
    add_row({52'h5_A5A5_A5A5_A5A5, 12'h0AA, 1'b1, 52'hA_5A5A_5A5A_5A5A, 1'b0}, 1'b1,
            {64'hA5A5_A5A5_A5A5_A0AA, 1'b0, 4'd1, 1'b1, PMAX, 1'b1});
    // hit re-marks slot 5 used, then a miss sweeps again, then write hits on slots 15 and 5
    add_row({52'h105, 12'h321, 1'b0, 52'h0, 1'b0}, 1'b0, '0);
    add_row({52'h7_7777_0000_7777, 12'h7F0, 1'b0, 52'h3_0000_0000_0003, 1'b1}, 1'b0, '0);
    add_row({52'h10F, 12'h00F, 1'b1, 52'h0, 1'b0}, 1'b0, '0);
    add_row({52'h105, 12'hF00, 1'b1, PMAX, 1'b1}, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].a, dir_rows[i].lit, dir_rows[i].x, pick_gap(i < 8));
    end

    // Random segments: each draws a fresh page pool. Pools under 16 pages mostly
    // hit; larger pools thrash and keep the clock sweep busy.
    for (int unsigned seg = 0; seg < RAND_SEGS; seg++) begin
      pool_n = $urandom_range(2, POOL_MAX);
      for (int unsigned p = 0; p < POOL_MAX; p++) page_pool[p] = rand_page();
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) a.page = page_pool[$urandom_range(0, pool_n - 1)];
        else if (r < 82) a.page = '0;
        else if (r < 84) a.page = PMAX;
        else a.page = rand_page();
        a.ofs    = OFS_W'($urandom());
        a.wr     = 1'($urandom());
        a.frame  = rand_page();
        a.wdirty = 1'($urandom());
        issue(a, 1'b0, '0, pick_gap(quiet));
      end
    end

    start <= 1'b0;
    while (xlate_q.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (TAIL_CYC) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard: far above ~925 beats of worst latency plus longest gaps
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
